[rtl/mck_pkg.sv]
package mck_pkg;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_NU_MODE   = 1'b0;
   localparam csr_index_type CSR_INV_RANGE = 1'b1;

   typedef enum logic [1:0] {
      NU_HALF        = 2'd0,
      NU_ONE_HALF    = 2'd1,
      NU_TWO_HALF    = 2'd2,
      NU_THREE_HALF  = 2'd3
   } nu_mode_type;

   localparam int COORD_W = 32;
   localparam int CORR_W  = 17;
   localparam int R16_W   = 21;
   localparam int POLY_W  = 28;
   localparam int EXP_W   = 33;
   localparam int ROOT_W  = 33;

   localparam logic [CORR_W-1:0] CORR_ONE = 17'h10000;
   localparam logic [POLY_W-1:0] POLY_ONE = 28'h0010000;

   // Reciprocals for exact floor division of 32-bit values by 3, 5 and 15.
   localparam logic [32:0] RECIP_3  = 33'(((65'd1 << 34) + 65'd2) / 65'd3);
   localparam logic [32:0] RECIP_5  = 33'(((65'd1 << 35) + 65'd4) / 65'd5);
   localparam logic [32:0] RECIP_15 = 33'(((65'd1 << 36) + 65'd14) / 65'd15);

   // Truncated alternating series of exp(-1) in Q0.32, evaluated at elaboration.
   function automatic logic [31:0] exp_one_q32();
      logic [63:0] term;
      logic [63:0] even;
      logic [63:0] odd;
      term = 64'd1 << 32;
      even = 64'd1 << 32;
      odd  = 64'd0;
      for (int k = 1; k <= 15; k++) begin
         term = term / 64'(k);
         if ((k % 2) == 1) odd = odd + term;
         else even = even + term;
      end
      return 32'(even - odd);
   endfunction

   localparam logic [31:0] EXP_ONE = exp_one_q32();

endpackage

[rtl/mck_if.sv]
interface mck_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] knot_x;
   logic signed [31:0] knot_y;

   modport source (output valid, point_x, point_y, knot_x, knot_y, input ready);
   modport sink (input valid, point_x, point_y, knot_x, knot_y, output ready);
endinterface

interface mck_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] correlation;

   modport source (output valid, correlation, input ready);
   modport sink (input valid, correlation, output ready);
endinterface

[rtl/mck_isqrt.sv]
module mck_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [64:0] in_radicand,
   output logic        out_valid,
   output logic [32:0] out_root
);
   import mck_pkg::*;

   localparam int STEPS = 32;

   logic [STEPS-1:0]  valid_ff;
   logic [ROOT_W-1:0] root_ff [STEPS];
   logic [35:0]       rem_ff  [STEPS];
   logic [63:0]       rad_ff  [STEPS];
   logic [ROOT_W-1:0] root_in [STEPS];
   logic [35:0]       rem_in  [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic              v_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [35:0]       rem_prev;
      logic [63:0]       rad_prev;
      logic [35:0]       rem_sh;
      logic [35:0]       trial;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign root_prev = {32'd0, in_radicand[64]};
         assign rem_prev  = 36'd0;
         assign rad_prev  = in_radicand[63:0];
      end else begin : g_next
         assign v_prev    = valid_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
      end

      assign rem_sh = {rem_prev[33:0], rad_prev[2*(STEPS-1-i)+1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in[i]  = rem_sh - trial;
            root_in[i] = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = rem_sh;
            root_in[i] = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[i] <= root_in[i];
            rem_ff[i]  <= rem_in[i];
            rad_ff[i]  <= rad_prev;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];

endmodule

[rtl/mck_exp.sv]
module mck_exp #(
   parameter int SIDE_W = 29
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [15:0]       in_frac,
   input  logic [4:0]        in_whole,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [32:0]       out_value,
   output logic [SIDE_W-1:0] out_side
);
   import mck_pkg::*;

   localparam int TERMS  = 14;
   localparam int POWERS = 31;

   logic [TERMS-1:0]  a_valid_ff;
   logic [31:0]       a_x_ff    [TERMS];
   logic [33:0]       a_even_ff [TERMS];
   logic [32:0]       a_odd_ff  [TERMS];
   logic [15:0]       a_frac_ff [TERMS];
   logic [4:0]        a_whole_ff[TERMS];
   logic [SIDE_W-1:0] a_side_ff [TERMS];
   logic [31:0]       a_x_in    [TERMS];
   logic [33:0]       a_even_in [TERMS];
   logic [32:0]       a_odd_in  [TERMS];

   logic [TERMS-1:0]  b_valid_ff;
   logic [31:0]       b_term_ff [TERMS];
   logic [33:0]       b_even_ff [TERMS];
   logic [32:0]       b_odd_ff  [TERMS];
   logic [15:0]       b_frac_ff [TERMS];
   logic [4:0]        b_whole_ff[TERMS];
   logic [SIDE_W-1:0] b_side_ff [TERMS];
   logic [31:0]       b_term_in [TERMS];

   logic              c_valid_ff;
   logic [EXP_W-1:0]  c_value_ff;
   logic [4:0]        c_whole_ff;
   logic [SIDE_W-1:0] c_side_ff;
   logic [33:0]       c_odd_sum;
   logic [EXP_W-1:0]  c_value_in;

   logic [POWERS-1:0] p_valid_ff;
   logic [EXP_W-1:0]  p_value_ff [POWERS];
   logic [4:0]        p_whole_ff [POWERS];
   logic [SIDE_W-1:0] p_side_ff  [POWERS];
   logic [EXP_W-1:0]  p_value_in [POWERS];

   for (genvar j = 0; j < TERMS; j++) begin : g_term
      localparam int K = j + 2;
      localparam int L = $clog2(K);
      localparam logic [32:0] RECIP = 33'(((65'd1 << (32 + L)) + 65'(K - 1)) / 65'(K));

      logic              v_prev;
      logic [31:0]       t_prev;
      logic [33:0]       even_prev;
      logic [32:0]       odd_prev;
      logic [15:0]       frac_prev;
      logic [4:0]        whole_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [47:0]       scaled;
      logic [64:0]       quot;

      if (j == 0) begin : g_first
         assign v_prev     = in_valid;
         assign t_prev     = {in_frac, 16'd0};
         assign even_prev  = 34'h100000000;
         assign odd_prev   = 33'd0;
         assign frac_prev  = in_frac;
         assign whole_prev = in_whole;
         assign side_prev  = in_side;
      end else begin : g_next
         assign v_prev     = b_valid_ff[j-1];
         assign t_prev     = b_term_ff[j-1];
         assign even_prev  = b_even_ff[j-1];
         assign odd_prev   = b_odd_ff[j-1];
         assign frac_prev  = b_frac_ff[j-1];
         assign whole_prev = b_whole_ff[j-1];
         assign side_prev  = b_side_ff[j-1];
      end

      // The incoming term has index K-1; it joins the sum matching its parity.
      always_comb begin
         scaled    = 48'(t_prev) * 48'(frac_prev);
         a_x_in[j] = scaled[47:16];
         if (((K - 1) % 2) == 1) begin
            a_even_in[j] = even_prev;
            a_odd_in[j]  = odd_prev + 33'(t_prev);
         end else begin
            a_even_in[j] = even_prev + 34'(t_prev);
            a_odd_in[j]  = odd_prev;
         end
      end

      always_comb begin
         quot         = 65'(a_x_ff[j]) * 65'(RECIP);
         b_term_in[j] = 32'(quot >> (32 + L));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[j] <= 1'b0;
            b_valid_ff[j] <= 1'b0;
         end else if (en) begin
            a_valid_ff[j] <= v_prev;
            b_valid_ff[j] <= a_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_x_ff[j]     <= a_x_in[j];
            a_even_ff[j]  <= a_even_in[j];
            a_odd_ff[j]   <= a_odd_in[j];
            a_frac_ff[j]  <= frac_prev;
            a_whole_ff[j] <= whole_prev;
            a_side_ff[j]  <= side_prev;
            b_term_ff[j]  <= b_term_in[j];
            b_even_ff[j]  <= a_even_ff[j];
            b_odd_ff[j]   <= a_odd_ff[j];
            b_frac_ff[j]  <= a_frac_ff[j];
            b_whole_ff[j] <= a_whole_ff[j];
            b_side_ff[j]  <= a_side_ff[j];
         end
      end
   end

   always_comb begin
      c_odd_sum = 34'(b_odd_ff[TERMS-1]) + 34'(b_term_ff[TERMS-1]);
      if (b_even_ff[TERMS-1] >= c_odd_sum) begin
         c_value_in = EXP_W'(b_even_ff[TERMS-1] - c_odd_sum);
      end else begin
         c_value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff[TERMS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_value_ff <= c_value_in;
         c_whole_ff <= b_whole_ff[TERMS-1];
         c_side_ff  <= b_side_ff[TERMS-1];
      end
   end

   for (genvar p = 0; p < POWERS; p++) begin : g_power
      logic              v_prev;
      logic [EXP_W-1:0]  value_prev;
      logic [4:0]        whole_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [64:0]       prod;

      if (p == 0) begin : g_first
         assign v_prev     = c_valid_ff;
         assign value_prev = c_value_ff;
         assign whole_prev = c_whole_ff;
         assign side_prev  = c_side_ff;
      end else begin : g_next
         assign v_prev     = p_valid_ff[p-1];
         assign value_prev = p_value_ff[p-1];
         assign whole_prev = p_whole_ff[p-1];
         assign side_prev  = p_side_ff[p-1];
      end

      always_comb begin
         prod = 65'(value_prev) * 65'(EXP_ONE);
         if (5'(p) < whole_prev) begin
            p_value_in[p] = EXP_W'(prod >> 32);
         end else begin
            p_value_in[p] = value_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            p_valid_ff[p] <= 1'b0;
         end else if (en) begin
            p_valid_ff[p] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p_value_ff[p] <= p_value_in[p];
            p_whole_ff[p] <= whole_prev;
            p_side_ff[p]  <= side_prev;
         end
      end
   end

   assign out_valid = p_valid_ff[POWERS-1];
   assign out_value = p_value_ff[POWERS-1];
   assign out_side  = p_side_ff[POWERS-1];

endmodule

[rtl/matern_correlation_kernel.sv]
// Pipeline: 3 stages for the distance, 32 for the square root, 2 for the range scaling,
// 4 for the polynomial, 60 for exp(-r) and 2 for the output.
// Throughput: one transaction per cycle while the skid stage is empty; the whole pipeline
// advances together, and the output register plus a one-entry skid stage stop the pipeline
// while the skid stage holds a response.
// Reset clears all valid bits and sets nu_mode to 1 and inv_range to 1.0.
module matern_correlation_kernel #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   mck_req_if.sink               req_ch,
   mck_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  mck_pkg::csr_index_type csr_index,
   input  logic [31:0]           csr_wr_data
);
   import mck_pkg::*;

   localparam logic [64:0] SAT_LIMIT = 65'd32 << (2 * FRAC_BITS);
   localparam int SIDE_W = POLY_W + 1;

   logic        en;
   nu_mode_type nu_mode_ff, nu_mode_in;
   logic [31:0] inv_range_ff, inv_range_in;

   logic        s1_valid_ff;
   logic [31:0] s1_mx_ff, s1_my_ff, s1_mx_in, s1_my_in;
   logic [32:0] dx, dy, dx_mag, dy_mag;
   logic        s2_valid_ff;
   logic [63:0] s2_a_ff, s2_b_ff;
   logic        s3_valid_ff;
   logic [64:0] s3_sum_ff;

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;

   logic        m1_valid_ff;
   logic [63:0] m1_p0_ff;
   logic        m1_dh_ff;
   logic        m2_valid_ff;
   logic        m2_sat_ff, m2_sat_in;
   logic [R16_W-1:0] m2_r16_ff, m2_r16_in;
   logic [64:0] full_prod, r_scaled;

   logic             p1_valid_ff, p1_sat_ff;
   logic [R16_W-1:0] p1_r16_ff;
   logic [25:0]      p1_r2_ff;
   logic             p2_valid_ff, p2_sat_ff;
   logic [R16_W-1:0] p2_r16_ff;
   logic [30:0]      p2_r3_ff, p2_r3_in;
   logic [25:0]      p2_q3_ff, p2_q3_in;
   logic [26:0]      p2_q5_ff, p2_q5_in;
   logic [46:0]      r3_wide;
   logic [58:0]      q3_wide;
   logic [59:0]      q5_wide;
   logic             p3_valid_ff, p3_sat_ff;
   logic [R16_W-1:0] p3_r16_ff;
   logic [25:0]      p3_q3_ff;
   logic [26:0]      p3_q5_ff;
   logic [26:0]      p3_q15_ff;
   logic [63:0]      q15_wide;
   logic             p4_valid_ff, p4_sat_ff;
   logic [R16_W-1:0] p4_r16_ff;
   logic [POLY_W-1:0] p4_poly_ff, p4_poly_in;

   logic              ex_valid;
   logic [EXP_W-1:0]  ex_value;
   logic [SIDE_W-1:0] ex_side;

   logic        f1_valid_ff, f1_sat_ff;
   logic [60:0] f1_prod_ff;
   logic [28:0] f1_hi;
   logic [CORR_W-1:0] corr;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CORR_W-1:0] rsp_data_ff, rsp_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [CORR_W-1:0] skid_data_ff, skid_data_in;

   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   always_comb begin
      nu_mode_in   = nu_mode_ff;
      inv_range_in = inv_range_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_NU_MODE:   nu_mode_in   = nu_mode_type'(csr_wr_data[1:0]);
            CSR_INV_RANGE: inv_range_in = csr_wr_data;
            default:       nu_mode_in   = nu_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nu_mode_ff   <= NU_ONE_HALF;
         inv_range_ff <= 32'h0001_0000;
      end else begin
         nu_mode_ff   <= nu_mode_in;
         inv_range_ff <= inv_range_in;
      end
   end

   always_comb begin
      dx       = {req_ch.point_x[31], req_ch.point_x} - {req_ch.knot_x[31], req_ch.knot_x};
      dy       = {req_ch.point_y[31], req_ch.point_y} - {req_ch.knot_y[31], req_ch.knot_y};
      dx_mag   = dx[32] ? (33'd0 - dx) : dx;
      dy_mag   = dy[32] ? (33'd0 - dy) : dy;
      s1_mx_in = dx_mag[31:0];
      s1_my_in = dy_mag[31:0];
   end

   always_comb begin
      full_prod = {1'b0, m1_p0_ff} + (m1_dh_ff ? {1'b0, inv_range_ff, 32'd0} : 65'd0);
      m2_sat_in = full_prod >= SAT_LIMIT;
   end

   if (FRAC_BITS >= 16) begin : g_r_down
      assign r_scaled = full_prod >> (2 * FRAC_BITS - 16);
   end else begin : g_r_up
      assign r_scaled = (full_prod >> FRAC_BITS) << (16 - FRAC_BITS);
   end
   assign m2_r16_in = r_scaled[R16_W-1:0];

   always_comb begin
      r3_wide  = 47'(p1_r2_ff) * 47'(p1_r16_ff);
      q3_wide  = 59'(p1_r2_ff) * 59'(RECIP_3);
      q5_wide  = 60'({p1_r2_ff, 1'b0}) * 60'(RECIP_5);
      p2_r3_in = r3_wide[46:16];
      p2_q3_in = 26'(q3_wide >> 34);
      p2_q5_in = 27'(q5_wide >> 35);
      q15_wide = 64'(p2_r3_ff) * 64'(RECIP_15);
   end

   always_comb begin
      case (nu_mode_ff)
         NU_HALF:       p4_poly_in = POLY_ONE;
         NU_ONE_HALF:   p4_poly_in = POLY_ONE + POLY_W'(p3_r16_ff);
         NU_TWO_HALF:   p4_poly_in = POLY_ONE + POLY_W'(p3_r16_ff) + POLY_W'(p3_q3_ff);
         NU_THREE_HALF: p4_poly_in = POLY_ONE + POLY_W'(p3_r16_ff) + POLY_W'(p3_q5_ff)
                                     + POLY_W'(p3_q15_ff);
         default:       p4_poly_in = POLY_ONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         m1_valid_ff <= sq_valid;
         m2_valid_ff <= m1_valid_ff;
         p1_valid_ff <= m2_valid_ff;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         f1_valid_ff <= ex_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mx_ff   <= s1_mx_in;
         s1_my_ff   <= s1_my_in;
         s2_a_ff    <= 64'(s1_mx_ff) * 64'(s1_mx_ff);
         s2_b_ff    <= 64'(s1_my_ff) * 64'(s1_my_ff);
         s3_sum_ff  <= 65'(s2_a_ff) + 65'(s2_b_ff);
         m1_p0_ff   <= 64'(sq_root[31:0]) * 64'(inv_range_ff);
         m1_dh_ff   <= sq_root[32];
         m2_sat_ff  <= m2_sat_in;
         m2_r16_ff  <= m2_r16_in;
         p1_sat_ff  <= m2_sat_ff;
         p1_r16_ff  <= m2_r16_ff;
         p1_r2_ff   <= 26'((42'(m2_r16_ff) * 42'(m2_r16_ff)) >> 16);
         p2_sat_ff  <= p1_sat_ff;
         p2_r16_ff  <= p1_r16_ff;
         p2_r3_ff   <= p2_r3_in;
         p2_q3_ff   <= p2_q3_in;
         p2_q5_ff   <= p2_q5_in;
         p3_sat_ff  <= p2_sat_ff;
         p3_r16_ff  <= p2_r16_ff;
         p3_q3_ff   <= p2_q3_ff;
         p3_q5_ff   <= p2_q5_ff;
         p3_q15_ff  <= 27'(q15_wide >> 36);
         p4_sat_ff  <= p3_sat_ff;
         p4_r16_ff  <= p3_r16_ff;
         p4_poly_ff <= p4_poly_in;
         f1_sat_ff  <= ex_side[SIDE_W-1];
         f1_prod_ff <= 61'(ex_value) * 61'(ex_side[POLY_W-1:0]);
      end
   end

   mck_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s3_valid_ff),
      .in_radicand (s3_sum_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root)
   );

   mck_exp #(
      .SIDE_W (SIDE_W)
   ) u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p4_valid_ff),
      .in_frac   (p4_r16_ff[15:0]),
      .in_whole  (p4_r16_ff[20:16]),
      .in_side   ({p4_sat_ff, p4_poly_ff}),
      .out_valid (ex_valid),
      .out_value (ex_value),
      .out_side  (ex_side)
   );

   always_comb begin
      f1_hi = f1_prod_ff[60:32];
      if (f1_sat_ff) begin
         corr = '0;
      end else if (f1_hi > 29'(CORR_ONE)) begin
         corr = CORR_ONE;
      end else begin
         corr = f1_hi[CORR_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_ch.ready || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = f1_valid_ff;
            rsp_data_in  = corr;
         end
      end else if (f1_valid_ff && en) begin
         skid_valid_in = 1'b1;
         skid_data_in  = corr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.correlation = rsp_data_ff;

endmodule

[rtl/mck_checker.sv]
module mck_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [16:0] rsp_correlation
);

   // A response never exceeds 1.0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_correlation <= 17'h10000))
      else $error("correlation above one");

   // A stalled response transaction keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_correlation))
      else $error("stalled response changed");

   // Request backpressure only appears while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // Backpressure starts only after a response was refused.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("request stall without response stall");

   // Nothing comes out right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind matern_correlation_kernel mck_checker u_mck_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_correlation (rsp_ch.correlation)
);

[tb/matern_correlation_kernel_test.sv]
`timescale 1ns / 100ps

module matern_correlation_kernel_test;
   import mck_pkg::*;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] knot_x;
      logic signed [31:0] knot_y;
   } pair_type;

   localparam int STALL_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   csr_index_type csr_index;
   logic [31:0] csr_wr_data;

   mck_req_if req_ch ();
   mck_rsp_if rsp_ch ();

   matern_correlation_kernel u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   pair_type    pending_pairs[$];
   logic [16:0] expected_corr[$];
   nu_mode_type model_nu;
   logic [31:0] model_inv_range;
   int          mismatches;
   int          accepted_pairs;
   int          idle_cycles;
   bit          quiet;
   bit          timed_out;
   bit          req_fire;
   bit          rsp_fire;
   bit          hold_armed;
   int          hold_left;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [63:0] exp_neg_q32(logic [16:0] f);
      logic [63:0] term;
      logic [63:0] even;
      logic [63:0] odd;
      term = 64'd1 << 32;
      even = 64'd1 << 32;
      odd  = 64'd0;
      for (int k = 1; k <= 15; k++) begin
         term = ((term * 64'(f)) >> 16) / 64'(k);
         if (k % 2 == 1) odd = odd + term;
         else even = even + term;
      end
      return (even >= odd) ? even - odd : 64'd0;
   endfunction

   function automatic logic [16:0] matern_corr(pair_type p, nu_mode_type nu,
                                               logic [31:0] inv);
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic [65:0]  sq_sum;
      logic [67:0]  rem;
      logic [67:0]  trial;
      logic [33:0]  root;
      logic [96:0]  prod;
      logic [20:0]  r16;
      logic [63:0]  e;
      logic [63:0]  e1;
      logic [63:0]  r2;
      logic [63:0]  r3;
      logic [63:0]  poly;
      logic [63:0]  ep;
      logic [63:0]  res;
      dx = 34'(p.point_x) - 34'(p.knot_x);
      dy = 34'(p.point_y) - 34'(p.knot_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq_sum = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
      rem  = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem   = (rem << 2) | 68'(sq_sum[2*i +: 2]);
         trial = (68'(root) << 2) | 68'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 34'd1;
         end else begin
            root = root << 1;
         end
      end
      prod = 97'(root) * 97'(inv);
      if (prod >= (97'd32 << 32)) return 17'd0;
      r16 = prod[36:16];
      e  = exp_neg_q32({1'b0, r16[15:0]});
      e1 = exp_neg_q32(17'h10000);
      for (int i = 0; i < 32; i++) begin
         if (i < r16[20:16]) e = (e * e1) >> 32;
      end
      r2 = (64'(r16) * 64'(r16)) >> 16;
      r3 = (r2 * 64'(r16)) >> 16;
      case (nu)
         NU_HALF:     poly = 64'h10000;
         NU_ONE_HALF: poly = 64'h10000 + 64'(r16);
         NU_TWO_HALF: poly = 64'h10000 + 64'(r16) + r2 / 3;
         default:     poly = 64'h10000 + 64'(r16) + (2 * r2) / 5 + r3 / 15;
      endcase
      ep  = e * poly;
      res = ep >> 32;
      if (res > 64'h10000) res = 64'h10000;
      return res[16:0];
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int       k;
      p.point_x = $urandom;
      p.point_y = $urandom;
      if ($urandom_range(99) < 25) begin
         p.knot_x = $urandom;
         p.knot_y = $urandom;
      end else begin
         k = $urandom_range(26);
         p.knot_x = p.point_x - ($signed(32'($urandom)) >>> (31 - k));
         p.knot_y = p.point_y - ($signed(32'($urandom)) >>> (31 - k));
      end
      return p;
   endfunction

   function automatic pair_type make_pair(int px, int py, int kx, int ky);
      pair_type p;
      p.point_x = px;
      p.point_y = py;
      p.knot_x  = kx;
      p.knot_y  = ky;
      return p;
   endfunction

   task automatic queue_pair(pair_type p);
      pending_pairs.insert(pending_pairs.size(), p);
   endtask

   // Sender: a held transaction stays on the bus until it is accepted.
   always @(negedge clock) begin
      logic     nxt_valid;
      pair_type nxt;
      nxt_valid = req_ch.valid;
      nxt = {req_ch.point_x, req_ch.point_y, req_ch.knot_x, req_ch.knot_y};
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         nxt_valid = 1'b0;
         if (pending_pairs.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
            nxt = pending_pairs.pop_front();
            nxt_valid = 1'b1;
         end
      end
      req_ch.valid   <= nxt_valid;
      req_ch.point_x <= nxt.point_x;
      req_ch.point_y <= nxt.point_y;
      req_ch.knot_x  <= nxt.knot_x;
      req_ch.knot_y  <= nxt.knot_y;
   end

   // Receiver: one long hold-off lets the pipeline fill and stall its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (!hold_armed && accepted_pairs >= 700) begin
         hold_armed = 1'b1;
         hold_left  = 400;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet || $urandom_range(99) >= 18;
      end
   end

   always @(posedge clock) begin
      logic [16:0] want;
      req_fire = req_ch.valid && req_ch.ready && !reset;
      rsp_fire = rsp_ch.valid && rsp_ch.ready && !reset;
      if (req_fire) begin
         expected_corr.insert(expected_corr.size(),
                              matern_corr({req_ch.point_x, req_ch.point_y,
                                           req_ch.knot_x, req_ch.knot_y},
                                          model_nu, model_inv_range));
         accepted_pairs++;
      end
      if (rsp_fire) begin
         if (expected_corr.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response transaction: correlation %0d",
                        rsp_ch.correlation);
         end else begin
            want = expected_corr.pop_front();
            if (rsp_ch.correlation !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Correlation mismatch: expected %0d, actual %0d",
                           want, rsp_ch.correlation);
            end
         end
      end
      if (req_fire || rsp_fire || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_NU_MODE) model_nu = nu_mode_type'(data[1:0]);
      else model_inv_range = data;
   endtask

   task automatic drain();
      while (pending_pairs.size() > 0 || req_ch.valid || expected_corr.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   initial begin
      logic [1:0]  phase_nu[8];
      logic [31:0] phase_inv[8];
      phase_nu  = '{2'd0, 2'd2, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3};
      phase_inv = '{32'h10000, 32'h8000, 32'h20000, 32'h0, 32'hFFFFFFFF, 32'h1,
                    32'h10000, 32'h3_4000};
      mismatches = 0;
      accepted_pairs = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      timed_out = 1'b0;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      hold_armed = 1'b0;
      hold_left = 0;
      model_nu = NU_ONE_HALF;
      model_inv_range = 32'h10000;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_NU_MODE;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.knot_x = '0;
      req_ch.knot_y = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed transactions under the reset configuration.
      queue_pair(make_pair(0, 0, 0, 0));
      queue_pair(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000));
      queue_pair(make_pair(32'h80000000, 0, 32'h7FFFFFFF, 0));
      queue_pair(make_pair(32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h80000000));
      queue_pair(make_pair(1, 0, 0, 0));
      queue_pair(make_pair(0, -1, 0, 0));
      queue_pair(make_pair(32 << 16, 0, 0, 0));
      queue_pair(make_pair((32 << 16) - 1, 0, 0, 0));
      queue_pair(make_pair(0, 0, 3 << 16, 4 << 16));
      queue_pair(make_pair(32'h00010000, 0, 0, 0));
      queue_pair(make_pair(-(5 << 16), 7 << 15, 2 << 16, -(3 << 16)));
      queue_pair(make_pair(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAB));
      for (int i = 0; i < 150; i++) queue_pair(random_pair());
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_NU_MODE, 32'(phase_nu[ph]));
         write_csr(CSR_INV_RANGE, phase_inv[ph]);
         if (ph == 1) begin
            write_csr(CSR_INV_RANGE, 32'h10000);
            quiet = 1'b1;
         end
         for (int i = 0; i < 160; i++) queue_pair(random_pair());
         drain();
         quiet = 1'b0;
      end

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
